// ===== design/sri_pkg.sv =====
// sri_pkg: shared widths, the term operation passed from front to back,
// the result record and the constant divide-by-three step.
// No dependencies.
`default_nettype none

package sri_pkg;

  localparam int unsigned SampleWidth  = 32;
  localparam int unsigned DiffWidth    = SampleWidth + 1;   // x1 - x0
  localparam int unsigned MagDiffWidth = SampleWidth;       // |x1 - x0|
  localparam int unsigned SumWidth     = SampleWidth + 3;   // y0 + 4*y1 + y2
  localparam int unsigned MagSumWidth  = SampleWidth + 2;   // |y sum|
  localparam int unsigned PartWidth    = SampleWidth / 2;   // split of |dx| for the multiply
  localparam int unsigned PpWidth      = PartWidth + MagSumWidth;
  localparam int unsigned ProdWidth    = MagDiffWidth + MagSumWidth;
  localparam int unsigned HalfWidth    = ProdWidth - 1;     // product after the divide by two
  localparam int unsigned LimbWidth    = 17;
  localparam int unsigned NumLimbs     = (HalfWidth + LimbWidth - 1) / LimbWidth;
  localparam int unsigned PadWidth     = NumLimbs * LimbWidth;
  localparam int unsigned TermWidth    = HalfWidth + 2;     // signed term
  localparam int unsigned AccumWidth   = 64;
  localparam int unsigned AccSumWidth  = TermWidth + 1;

  // floor(n/3) for n < 3*2^LimbWidth as (n * Recip3) >> Recip3Shift
  localparam int unsigned Recip3Width  = 20;
  localparam int unsigned Recip3Shift  = 21;
  localparam logic [Recip3Width-1:0] Recip3 = 20'd699051;
  localparam int unsigned Div3ProdWidth = LimbWidth + 2 + Recip3Width;

  typedef struct packed {
    logic                        has_term;
    logic                        div6;      // 1: divide by six, 0: divide by two
    logic                        last;      // closes the row, emit the sum
    logic signed [DiffWidth-1:0] dx;
    logic signed [SumWidth-1:0]  ysum;
  } op_t;

  typedef struct packed {
    logic neg;
    logic div6;
    logic has_term;
    logic last;
  } tag_t;

  typedef struct packed {
    logic signed [AccumWidth-1:0] integral;
    logic                         overflow;
  } result_t;

  // one long-division step by three: returns {quotient limb, remainder}
  function automatic logic [LimbWidth+1:0] div3_step(input logic [1:0]           rem_in,
                                                     input logic [LimbWidth-1:0] limb);
    logic [LimbWidth+1:0]     num;
    logic [Div3ProdWidth-1:0] prod;
    logic [LimbWidth-1:0]     quo;
    logic [LimbWidth+1:0]     back;
    num  = {rem_in, limb};
    prod = Div3ProdWidth'(num) * Div3ProdWidth'(Recip3);
    quo  = prod[Recip3Shift +: LimbWidth];
    back = num - ({2'b00, quo} + {1'b0, quo, 1'b0});
    return {quo, back[1:0]};
  endfunction

endpackage

`default_nettype wire

// ===== design/sri_front.sv =====
// sri_front: takes samples, keeps the pending samples of the row and the rule
// mode, and turns each sample into term operations for the back end.
// Depends on sri_pkg.
`default_nettype none

module sri_front import sri_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic signed [SampleWidth-1:0] x_value_i,
  input  logic signed [SampleWidth-1:0] y_value_i,
  input  logic                          end_of_row_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_data_i,
  output logic                          op_push_o,
  output op_t                           op_o,
  input  logic                          op_full_i
);

  localparam logic [1:0] PhaseStart = 2'd0;
  localparam logic [1:0] PhaseOne   = 2'd1;
  localparam logic [1:0] PhaseTwo   = 2'd2;

  logic                          mode_q;
  logic [1:0]                    phase_q, phase_d;
  logic signed [SampleWidth-1:0] px_q, px_d, py_q, py_d, ox_q, ox_d, oy_q, oy_d;
  op_t                           spill_q, spill_d;
  logic                          spill_valid_q, spill_valid_d;

  logic accept;
  op_t  op1, op2, trap_new, trap_pend, simp;
  logic op1_v, op2_v;

  assign full_o      = spill_valid_q | op_full_i;
  assign accept      = push_i & ~full_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    trap_new.has_term  = 1'b1;
    trap_new.div6      = 1'b0;
    trap_new.last      = 1'b0;
    trap_new.dx        = DiffWidth'(x_value_i) - DiffWidth'(px_q);
    trap_new.ysum      = SumWidth'(py_q) + SumWidth'(y_value_i);

    trap_pend.has_term = 1'b1;
    trap_pend.div6     = 1'b0;
    trap_pend.last     = 1'b0;
    trap_pend.dx       = DiffWidth'(px_q) - DiffWidth'(ox_q);
    trap_pend.ysum     = SumWidth'(oy_q) + SumWidth'(py_q);

    simp.has_term      = 1'b1;
    simp.div6          = 1'b1;
    simp.last          = 1'b0;
    simp.dx            = DiffWidth'(x_value_i) - DiffWidth'(ox_q);
    simp.ysum          = SumWidth'(oy_q) + (SumWidth'(py_q) <<< 2) + SumWidth'(y_value_i);
  end

  always_comb begin
    op1     = '0;
    op2     = '0;
    op1_v   = 1'b0;
    op2_v   = 1'b0;
    phase_d = phase_q;
    px_d    = px_q;
    py_d    = py_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    if (accept) begin
      px_d = x_value_i;
      py_d = y_value_i;
      unique case (phase_q)
        PhaseOne: begin
          if (mode_q) begin
            // second sample of a pair; a row ending here gets the trapezoid tail
            op1      = trap_new;
            op1.last = 1'b1;
            op1_v    = end_of_row_i;
            ox_d     = px_q;
            oy_d     = py_q;
            phase_d  = end_of_row_i ? PhaseStart : PhaseTwo;
          end else begin
            op1      = trap_new;
            op1.last = end_of_row_i;
            op1_v    = 1'b1;
            phase_d  = end_of_row_i ? PhaseStart : PhaseOne;
          end
        end
        PhaseTwo: begin
          if (mode_q) begin
            op1      = simp;
            op1.last = end_of_row_i;
            op1_v    = 1'b1;
          end else begin
            // mode went to trapezoid with a pair open: close the pending interval first
            op1      = trap_pend;
            op1_v    = 1'b1;
            op2      = trap_new;
            op2.last = end_of_row_i;
            op2_v    = 1'b1;
          end
          phase_d = end_of_row_i ? PhaseStart : PhaseOne;
        end
        default: begin
          op1.last = 1'b1;
          op1_v    = end_of_row_i;
          phase_d  = end_of_row_i ? PhaseStart : PhaseOne;
        end
      endcase
    end
  end

  always_comb begin
    spill_valid_d = spill_valid_q;
    spill_d       = spill_q;
    if (spill_valid_q && !op_full_i) begin
      spill_valid_d = 1'b0;
    end
    if (accept && op2_v) begin
      spill_valid_d = 1'b1;
      spill_d       = op2;
    end
  end

  assign op_push_o = spill_valid_q ? ~op_full_i : (accept & op1_v);
  assign op_o      = spill_valid_q ? spill_q : op1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= 1'b1;
      phase_q       <= PhaseStart;
      spill_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
      phase_q       <= phase_d;
      spill_valid_q <= spill_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q    <= px_d;
    py_q    <= py_d;
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    spill_q <= spill_d;
  end

endmodule

`default_nettype wire

// ===== design/sri_op_queue.sv =====
// sri_op_queue: four-entry queue of term operations between front and back.
// Depends on sri_pkg.
`default_nettype none

module sri_op_queue import sri_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  data_i,
  output logic full_o,
  input  logic pop_i,
  output op_t  data_o,
  output logic empty_o
);

  localparam int unsigned Depth    = 4;
  localparam int unsigned PtrWidth = $clog2(Depth);

  op_t                 mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrWidth:0]   cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == (PtrWidth+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/sri_back.sv =====
// sri_back: multiply, divide by two or six with floor rounding, saturating
// accumulate, and a two-entry result buffer.
// Depends on sri_pkg.
`default_nettype none

module sri_back import sri_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         op_empty_i,
  input  op_t                          op_i,
  output logic                         op_pop_o,
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic signed [AccumWidth-1:0] integral_o,
  output logic                         overflow_o
);

  localparam int unsigned ResDepth    = 2;
  localparam int unsigned ResPtrWidth = $clog2(ResDepth);
  localparam int unsigned NumStages   = 5;
  localparam logic signed [AccSumWidth-1:0] AccHiLim =
    {{(AccSumWidth-AccumWidth+1){1'b0}}, {(AccumWidth-1){1'b1}}};
  localparam logic signed [AccSumWidth-1:0] AccLoLim = ~AccHiLim;

  logic adv;
  logic [NumStages-1:0] stage_valid_q;
  tag_t s0_tag_q, s1_tag_q, s2_tag_q, s3_tag_q, s4_tag_q;

  // stage 0: magnitudes and sign
  logic [DiffWidth-1:0]    dx_mag_full;
  logic [SumWidth-1:0]     ys_mag_full;
  tag_t                    s0_tag_d;
  logic [MagDiffWidth-1:0] mag_dx_q;
  logic [MagSumWidth-1:0]  mag_ys_q;

  // stage 1: partial products
  logic [PpWidth-1:0] pp_lo_q, pp_hi_q;

  // stage 2: full product
  logic [ProdWidth-1:0] prod_q;

  // stage 3: upper quotient limbs
  logic [PadWidth-1:0]            pad_hi;
  logic [LimbWidth+1:0]           step3, step2;
  logic [HalfWidth-1:0]           half_q;
  logic                           p0_q;
  logic [2*LimbWidth-1:0]         qhi_q;
  logic [1:0]                     rem_mid_q;

  // stage 4: lower quotient limbs
  logic [PadWidth-1:0]  pad_lo;
  logic [LimbWidth+1:0] step1, step0;
  logic [PadWidth-1:0]  quo_full;
  logic [HalfWidth-1:0] quo_q;
  logic                 rem_nz_q;

  // accumulate
  logic [HalfWidth:0]              mag;
  logic signed [TermWidth-1:0]     term;
  logic signed [AccSumWidth-1:0]   sum;
  logic signed [AccumWidth-1:0]    acc_q, acc_new;
  logic                            flag_q, flag_new, sat;

  // result buffer
  result_t                res_mem_q [ResDepth];
  logic [ResPtrWidth-1:0] res_wr_q, res_rd_q;
  logic [ResPtrWidth:0]   res_cnt_q;
  logic                   res_push, res_pop;
  logic                   acc_fire;

  assign res_pop  = pop_i & (res_cnt_q != '0);
  assign adv      = (res_cnt_q != (ResPtrWidth+1)'(ResDepth)) | pop_i;
  assign op_pop_o = adv & ~op_empty_i;
  assign acc_fire = adv & stage_valid_q[NumStages-1];
  assign res_push = acc_fire & s4_tag_q.last;

  always_comb begin
    dx_mag_full       = op_i.dx[DiffWidth-1] ? -op_i.dx : op_i.dx;
    ys_mag_full       = op_i.ysum[SumWidth-1] ? -op_i.ysum : op_i.ysum;
    s0_tag_d.neg      = op_i.dx[DiffWidth-1] ^ op_i.ysum[SumWidth-1];
    s0_tag_d.div6     = op_i.div6;
    s0_tag_d.has_term = op_i.has_term;
    s0_tag_d.last     = op_i.last;
  end

  // divide by two first, then by three one limb per step
  always_comb begin
    pad_hi = PadWidth'(prod_q[ProdWidth-1:1]);
    step3  = div3_step(2'b00, pad_hi[3*LimbWidth +: LimbWidth]);
    step2  = div3_step(step3[1:0], pad_hi[2*LimbWidth +: LimbWidth]);
  end

  always_comb begin
    pad_lo   = PadWidth'(half_q);
    step1    = div3_step(rem_mid_q, pad_lo[LimbWidth +: LimbWidth]);
    step0    = div3_step(step1[1:0], pad_lo[0 +: LimbWidth]);
    quo_full = {qhi_q, step1[LimbWidth+1:2], step0[LimbWidth+1:2]};
  end

  // floor rounding: a negative term with a remainder moves one further down
  always_comb begin
    mag  = {1'b0, quo_q} + (HalfWidth+1)'(s4_tag_q.neg & rem_nz_q);
    term = s4_tag_q.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    if (!s4_tag_q.has_term) begin
      term = '0;
    end
    sum = AccSumWidth'(acc_q) + AccSumWidth'(term);
    sat = 1'b0;
    if (sum > AccHiLim) begin
      acc_new = AccHiLim[AccumWidth-1:0];
      sat     = 1'b1;
    end else if (sum < AccLoLim) begin
      acc_new = AccLoLim[AccumWidth-1:0];
      sat     = 1'b1;
    end else begin
      acc_new = sum[AccumWidth-1:0];
    end
    flag_new = flag_q | sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= '0;
      acc_q         <= '0;
      flag_q        <= 1'b0;
      res_wr_q      <= '0;
      res_rd_q      <= '0;
      res_cnt_q     <= '0;
    end else begin
      if (adv) begin
        stage_valid_q <= {stage_valid_q[NumStages-2:0], ~op_empty_i};
      end
      if (acc_fire) begin
        if (s4_tag_q.last) begin
          acc_q  <= '0;
          flag_q <= 1'b0;
        end else begin
          acc_q  <= acc_new;
          flag_q <= flag_new;
        end
      end
      if (res_push) begin
        res_wr_q <= res_wr_q + 1'b1;
      end
      if (res_pop) begin
        res_rd_q <= res_rd_q + 1'b1;
      end
      if (res_push && !res_pop) begin
        res_cnt_q <= res_cnt_q + 1'b1;
      end else if (res_pop && !res_push) begin
        res_cnt_q <= res_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_tag_q  <= s0_tag_d;
      mag_dx_q  <= dx_mag_full[MagDiffWidth-1:0];
      mag_ys_q  <= ys_mag_full[MagSumWidth-1:0];

      s1_tag_q  <= s0_tag_q;
      pp_lo_q   <= PpWidth'(mag_dx_q[PartWidth-1:0]) * PpWidth'(mag_ys_q);
      pp_hi_q   <= PpWidth'(mag_dx_q[MagDiffWidth-1:PartWidth]) * PpWidth'(mag_ys_q);

      s2_tag_q  <= s1_tag_q;
      prod_q    <= ProdWidth'(pp_lo_q) + (ProdWidth'(pp_hi_q) << PartWidth);

      s3_tag_q  <= s2_tag_q;
      half_q    <= prod_q[ProdWidth-1:1];
      p0_q      <= prod_q[0];
      qhi_q     <= {step3[LimbWidth+1:2], step2[LimbWidth+1:2]};
      rem_mid_q <= step2[1:0];

      s4_tag_q  <= s3_tag_q;
      quo_q     <= s3_tag_q.div6 ? quo_full[HalfWidth-1:0] : half_q;
      rem_nz_q  <= p0_q | (s3_tag_q.div6 & (step0[1:0] != 2'b00));
    end
    if (res_push) begin
      res_mem_q[res_wr_q].integral <= acc_new;
      res_mem_q[res_wr_q].overflow <= flag_new;
    end
  end

  assign empty_o    = (res_cnt_q == '0);
  assign integral_o = res_mem_q[res_rd_q].integral;
  assign overflow_o = res_mem_q[res_rd_q].overflow;

endmodule

`default_nettype wire

// ===== design/simpson_row_integrator_unit.sv =====
// simpson_row_integrator_unit: streaming row integrator, Simpson pairs with a
// trapezoid tail or plain trapezoid. Depends on sri_pkg, sri_front,
// sri_op_queue and sri_back.
//
//   channel   handshake             beat contents
//   samples   push / full           x_value_i, y_value_i, end_of_row_i
//   results   pop / empty           integral_o, overflow_o
//   config    cfg_valid_i / ready   cfg_data_i (rule mode, 1 = Simpson)
//
// One sample per cycle while full is low; a trapezoid sample that finds an open
// Simpson pair needs two term slots and holds full while the second waits in the spill slot.
// After the edge that takes its last sample, a row's result goes through the
// queue write, magnitudes, multiply in two steps, divide by three in two limb
// steps and accumulate into the result buffer; a last term that goes through
// the spill slot waits there before its queue write.
// Reset clears all control state and sets the rule mode to Simpson.
// A full result buffer stalls the back end only; the front keeps taking
// samples until the four-entry operation queue fills.
`default_nettype none

module simpson_row_integrator_unit import sri_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic signed [SampleWidth-1:0] x_value_i,
  input  logic signed [SampleWidth-1:0] y_value_i,
  input  logic                          end_of_row_i,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [AccumWidth-1:0]  integral_o,
  output logic                          overflow_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_data_i
);

  op_t  fe_op, q_op;
  logic fe_push, q_full, q_empty, be_pop;

  sri_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .x_value_i    (x_value_i),
    .y_value_i    (y_value_i),
    .end_of_row_i (end_of_row_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .op_push_o    (fe_push),
    .op_o         (fe_op),
    .op_full_i    (q_full)
  );

  sri_op_queue u_op_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .data_i  (fe_op),
    .full_o  (q_full),
    .pop_i   (be_pop),
    .data_o  (q_op),
    .empty_o (q_empty)
  );

  sri_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_empty_i (q_empty),
    .op_i       (q_op),
    .op_pop_o   (be_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .integral_o (integral_o),
    .overflow_o (overflow_o)
  );

endmodule

`default_nettype wire
